### rtl/drp_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the deflection router permuter.
// No dependencies; every other file in rtl/ imports this package.
package drp_pkg;

   // Flit word layout: bit0 valid, bits3:1 direction, flit number, packet id
   localparam int FLIT_NUM_BITS = 8;
   localparam int PKT_ID_BITS   = 16;
   localparam int DIR_LSB       = 1;
   localparam int FNUM_LSB      = 4;
   localparam int PKT_LSB       = FNUM_LSB + FLIT_NUM_BITS;
   localparam int FLIT_BITS     = PKT_LSB + PKT_ID_BITS;
   localparam int NETWORK_PORTS = 4;
   localparam int PORT_IDX_BITS = $clog2(NETWORK_PORTS);
   localparam int DEFL_BITS     = $clog2(NETWORK_PORTS + 1);

   // Configuration registers
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CFG_BITS      = 16;
   localparam int CYCLE_BITS    = CFG_BITS + 1;

   typedef logic [FLIT_BITS-1:0]     flit_type;
   typedef logic [2:0]               dir_type;
   typedef logic [FLIT_NUM_BITS-1:0] fnum_type;
   typedef logic [PKT_ID_BITS-1:0]   pkt_type;
   typedef logic [CFG_BITS-1:0]      cfg_type;
   typedef logic [1:0]               csr_idx_type;

   // Registered flit slot: packed word plus golden mark
   typedef struct packed {
      logic     gold;
      flit_type word;
   } slot_type;

   // Direction codes
   localparam dir_type DIR_XP    = 3'd0;
   localparam dir_type DIR_XM    = 3'd1;
   localparam dir_type DIR_YP    = 3'd2;
   localparam dir_type DIR_YM    = 3'd3;
   localparam dir_type DIR_LOCAL = 3'd4;

   // Desired direction of each permuter output (north, south, east, west)
   localparam dir_type WANT_DIR [NETWORK_PORTS] = '{DIR_YP, DIR_YM, DIR_XP, DIR_XM};

   // Register indexes (byte address = 4 * index)
   localparam csr_idx_type CSR_EPOCH_LENGTH = 2'd0;
   localparam csr_idx_type CSR_MAX_INJECT   = 2'd1;
   localparam csr_idx_type CSR_LFSR_SEED    = 2'd2;

   // Reset values
   localparam cfg_type EPOCH_LENGTH_RST = 16'd132;
   localparam cfg_type MAX_INJECT_RST   = 16'd65535;
   localparam cfg_type LFSR_SEED_RST    = 16'd1;
   localparam pkt_type GOLDEN_ID_RST    = 16'd1;

   function automatic dir_type dir_of(flit_type w);
      return w[DIR_LSB +: 3];
   endfunction

   function automatic fnum_type fnum_of(flit_type w);
      return w[FNUM_LSB +: FLIT_NUM_BITS];
   endfunction

   function automatic pkt_type pkt_of(flit_type w);
      return w[PKT_LSB +: PKT_ID_BITS];
   endfunction

   // x^16+x^14+x^13+x^11+1, shifting right
   function automatic cfg_type lfsr_step(cfg_type l);
      logic fb;
      fb = l[0] ^ l[2] ^ l[3] ^ l[5];
      return {fb, l[CFG_BITS-1:1]};
   endfunction

   // A tie between two plain present flits takes a random bit
   function automatic logic pick_draws(slot_type a, slot_type b);
      logic va, vb;
      va = a.word[0];
      vb = b.word[0];
      return va && vb && !a.gold && !b.gold;
   endfunction

   // Winner of two flits: 0 selects a, 1 selects b
   function automatic logic pick_sel(slot_type a, slot_type b, logic rbit);
      logic va, vb, ga, gb, w;
      va = a.word[0];
      vb = b.word[0];
      ga = va && a.gold;
      gb = vb && b.gold;
      if (ga && gb)   w = (fnum_of(b.word) < fnum_of(a.word));
      else if (ga)    w = 1'b0;
      else if (gb)    w = 1'b1;
      else if (!vb)   w = 1'b0;
      else if (!va)   w = 1'b1;
      else            w = rbit;
      return w;
   endfunction

   // Output half a flit wants in the given permuter stage
   function automatic logic steer(flit_type w, logic second);
      dir_type d;
      d = dir_of(w);
      if (!second) return (d == DIR_XP) || (d == DIR_XM);
      return (d == DIR_YM) || (d == DIR_XM);
   endfunction

   // 2x2 permuter: swap the pair when the winner wants the other output
   function automatic logic perm_swap(slot_type a, slot_type b, logic second, logic rbit);
      logic w, p0, p1;
      w  = pick_sel(a, b, rbit);
      p0 = a.word[0] ? steer(a.word, second) : 1'b0;
      p1 = b.word[0] ? steer(b.word, second) : 1'b1;
      if (!a.word[0] && !b.word[0]) return 1'b0;
      return (!w && p0) || (w && !p1);
   endfunction

endpackage

### rtl/drp_req_if.sv
`timescale 1ns / 1ps
// Transaction channels of the deflection router permuter: arrivals in, results out.
// Depends on drp_pkg for the flit type.
interface drp_req_if;
   import drp_pkg::*;

   logic     valid;
   logic     ready;
   flit_type in_slot_1;
   flit_type in_slot_2;
   flit_type in_slot_3;
   flit_type in_slot_4;
   flit_type inject_word;

   modport source (output valid, in_slot_1, in_slot_2, in_slot_3, in_slot_4, inject_word,
                   input ready);
   modport sink (input valid, in_slot_1, in_slot_2, in_slot_3, in_slot_4, inject_word,
                 output ready);
endinterface

interface drp_rsp_if;
   import drp_pkg::*;

   logic                 valid;
   logic                 ready;
   flit_type             north_flit;
   flit_type             south_flit;
   flit_type             east_flit;
   flit_type             west_flit;
   flit_type             eject_flit;
   logic [DEFL_BITS-1:0] deflections;
   logic                 inject_stop;
   logic                 inject_dropped;

   modport source (output valid, north_flit, south_flit, east_flit, west_flit, eject_flit,
                   deflections, inject_stop, inject_dropped,
                   input ready);
   modport sink (input valid, north_flit, south_flit, east_flit, west_flit, eject_flit,
                 deflections, inject_stop, inject_dropped,
                 output ready);
endinterface

### rtl/deflection_router_permuter_core.sv
`timescale 1ns / 1ps
// Bufferless deflection router permuter: ejection, injection queue, golden epoch,
// two-stage permuter network. Depends on drp_pkg and drp_req_if.sv interfaces.
//
// Usage:
//  - req_if carries one router cycle per transaction: four arriving link flits and
//    one local flit offered for injection. rsp_if returns one transaction per
//    request: the four link outputs, the ejected flit, the deflection count and
//    the injection queue flags.
//  - The link outputs of a request come from the flits registered by the
//    previous request; the arrivals of this request are ejected, topped up from
//    the queue and held in the stage registers for the next one.
//  - The response is registered: a request accepted at an edge shows its
//    response from that edge on. One request per cycle is sustained while
//    responses are taken; the step is one combinational pass between the stage
//    and response registers, through up to seven chained LFSR tie-break draws.
//  - req_if.ready is low only while a response is held and rsp_if.ready is low;
//    a stalled response holds and no state moves until it is taken.
//  - Reset (synchronous) empties the stage slots and the injection queue, sets
//    golden id to one, epoch phase to zero and loads the registers with their
//    defaults. No clearing pass is needed.
//  - csr_*: APB-style port, epoch_length at 0x0, max_inject at 0x4, lfsr_seed at
//    0x8. Writing lfsr_seed reloads the generator (zero loads one). Write only
//    while no response is outstanding.
module deflection_router_permuter_core #(
   parameter int INJ_QUEUE_DEPTH = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   drp_req_if.sink                               req_if,
   drp_rsp_if.source                             rsp_if,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [drp_pkg::CSR_ADDR_BITS-1:0]     csr_paddr,
   input  logic [drp_pkg::CSR_DATA_BITS-1:0]     csr_pwdata,
   output logic [drp_pkg::CSR_DATA_BITS-1:0]     csr_prdata,
   output logic                                  csr_pready
);
   import drp_pkg::*;

   localparam int QCNT_BITS = $clog2(INJ_QUEUE_DEPTH + 1);

   // Configuration registers
   cfg_type epoch_length_ff;
   cfg_type max_inject_ff;
   cfg_type lfsr_seed_ff;

   // Router state
   slot_type                stage_ff [NETWORK_PORTS];
   slot_type                stage_in [NETWORK_PORTS];
   flit_type                queue_ff [INJ_QUEUE_DEPTH];
   flit_type                queue_in [INJ_QUEUE_DEPTH];
   flit_type                queue_shift [INJ_QUEUE_DEPTH];
   logic [QCNT_BITS-1:0]    qcount_ff;
   logic [QCNT_BITS-1:0]    qcount_in;
   pkt_type                 golden_ff;
   pkt_type                 golden_in;
   logic [CYCLE_BITS-1:0]   cycle_ff;
   logic [CYCLE_BITS-1:0]   cycle_in;
   cfg_type                 lfsr_ff;
   cfg_type                 lfsr_in;

   // Response register
   logic                    rsp_valid_ff;
   flit_type                link_out_ff [NETWORK_PORTS];
   flit_type                eject_ff;
   logic [DEFL_BITS-1:0]    defl_ff;
   logic                    stop_ff;
   logic                    dropped_ff;

   // Step logic
   logic                    accept;
   logic                    csr_write;
   csr_idx_type             csr_idx;
   cfg_type                 epoch;
   flit_type                in_word [NETWORK_PORTS];
   slot_type                arr [NETWORK_PORTS];
   slot_type                mid [NETWORK_PORTS];
   slot_type                net_out [NETWORK_PORTS];
   flit_type                link_out [NETWORK_PORTS];
   logic [NETWORK_PORTS-1:0] defl_bit;
   logic [DEFL_BITS-1:0]    defl_sum;
   logic [NETWORK_PORTS-1:0] want_eject;
   logic                    swap_a, swap_b, swap_c, swap_d;
   logic                    ea_ok, eb_ok, sel_ok, sel_w;
   logic [PORT_IDX_BITS-1:0] ea, eb, sel, free_idx;
   logic                    free_ok;
   slot_type                post [NETWORK_PORTS];
   flit_type                eject_word;
   cfg_type                 lfsr_walk;
   flit_type                offer, head;
   logic                    push, pop, dropped;
   logic [QCNT_BITS-1:0]    qcount_push;

   assign accept    = req_if.valid && req_if.ready;
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx   = csr_paddr[3:2];

   // Register readback
   always_comb begin
      csr_prdata = '0;
      case (csr_idx)
         CSR_EPOCH_LENGTH: csr_prdata = CSR_DATA_BITS'(epoch_length_ff);
         CSR_MAX_INJECT:   csr_prdata = CSR_DATA_BITS'(max_inject_ff);
         CSR_LFSR_SEED:    csr_prdata = CSR_DATA_BITS'(lfsr_seed_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // Golden epoch advance
   always_comb begin
      epoch = (epoch_length_ff == '0) ? cfg_type'(1) : epoch_length_ff;
      if (cycle_ff >= {1'b0, epoch}) begin
         golden_in = (golden_ff >= max_inject_ff) ? pkt_type'(1) : golden_ff + pkt_type'(1);
         cycle_in  = CYCLE_BITS'(1);
      end else begin
         golden_in = golden_ff;
         cycle_in  = cycle_ff + CYCLE_BITS'(1);
      end
   end

   // Arrivals, marked golden against the new golden id
   assign in_word[0] = req_if.in_slot_1;
   assign in_word[1] = req_if.in_slot_2;
   assign in_word[2] = req_if.in_slot_3;
   assign in_word[3] = req_if.in_slot_4;

   always_comb begin
      for (int k = 0; k < NETWORK_PORTS; k++) begin
         arr[k].word   = in_word[k][0] ? in_word[k] : '0;
         arr[k].gold   = in_word[k][0] && (pkt_of(in_word[k]) == golden_in);
         want_eject[k] = in_word[k][0] && (dir_of(in_word[k]) == DIR_LOCAL);
      end
   end

   // Permuter network on the stored flits, then the ejection tree;
   // tie-break draws are taken from the LFSR in this fixed order
   always_comb begin
      lfsr_walk = lfsr_ff;

      // stage one: (slot 4, slot 2) and (slot 3, slot 1)
      swap_a = perm_swap(stage_ff[3], stage_ff[1], 1'b0, lfsr_walk[0]);
      if (pick_draws(stage_ff[3], stage_ff[1])) lfsr_walk = lfsr_step(lfsr_walk);
      mid[0] = swap_a ? stage_ff[1] : stage_ff[3];
      mid[1] = swap_a ? stage_ff[3] : stage_ff[1];

      swap_b = perm_swap(stage_ff[2], stage_ff[0], 1'b0, lfsr_walk[0]);
      if (pick_draws(stage_ff[2], stage_ff[0])) lfsr_walk = lfsr_step(lfsr_walk);
      mid[2] = swap_b ? stage_ff[0] : stage_ff[2];
      mid[3] = swap_b ? stage_ff[2] : stage_ff[0];

      // stage two
      swap_c = perm_swap(mid[0], mid[2], 1'b1, lfsr_walk[0]);
      if (pick_draws(mid[0], mid[2])) lfsr_walk = lfsr_step(lfsr_walk);
      net_out[0] = swap_c ? mid[2] : mid[0];
      net_out[1] = swap_c ? mid[0] : mid[2];

      swap_d = perm_swap(mid[1], mid[3], 1'b1, lfsr_walk[0]);
      if (pick_draws(mid[1], mid[3])) lfsr_walk = lfsr_step(lfsr_walk);
      net_out[2] = swap_d ? mid[3] : mid[1];
      net_out[3] = swap_d ? mid[1] : mid[3];

      // ejection: pairwise winners, then the final pick
      ea_ok = want_eject[0] || want_eject[1];
      ea    = want_eject[0] ? PORT_IDX_BITS'(0) : PORT_IDX_BITS'(1);
      if (want_eject[0] && want_eject[1]) begin
         ea = pick_sel(arr[0], arr[1], lfsr_walk[0]) ? PORT_IDX_BITS'(1) : PORT_IDX_BITS'(0);
         if (pick_draws(arr[0], arr[1])) lfsr_walk = lfsr_step(lfsr_walk);
      end

      eb_ok = want_eject[2] || want_eject[3];
      eb    = want_eject[2] ? PORT_IDX_BITS'(2) : PORT_IDX_BITS'(3);
      if (want_eject[2] && want_eject[3]) begin
         eb = pick_sel(arr[2], arr[3], lfsr_walk[0]) ? PORT_IDX_BITS'(3) : PORT_IDX_BITS'(2);
         if (pick_draws(arr[2], arr[3])) lfsr_walk = lfsr_step(lfsr_walk);
      end

      sel_ok = ea_ok || eb_ok;
      sel    = ea_ok ? ea : eb;
      sel_w  = 1'b0;
      if (ea_ok && eb_ok) begin
         sel_w = pick_sel(arr[ea], arr[eb], lfsr_walk[0]);
         if (pick_draws(arr[ea], arr[eb])) lfsr_walk = lfsr_step(lfsr_walk);
         sel = sel_w ? eb : ea;
      end

      lfsr_in = lfsr_walk;
   end

   // Link outputs and deflection count
   always_comb begin
      defl_sum = '0;
      for (int k = 0; k < NETWORK_PORTS; k++) begin
         link_out[k] = net_out[k].word[0] ? net_out[k].word : '0;
         defl_bit[k] = net_out[k].word[0] && (dir_of(net_out[k].word) != WANT_DIR[k]);
         defl_sum    = defl_sum + DEFL_BITS'(defl_bit[k]);
      end
   end

   // Remove the ejected flit, find the lowest free slot
   always_comb begin
      eject_word = sel_ok ? arr[sel].word : '0;
      free_ok    = 1'b0;
      free_idx   = '0;
      for (int k = 0; k < NETWORK_PORTS; k++) begin
         post[k] = arr[k];
         if (sel_ok && (sel == PORT_IDX_BITS'(k))) post[k] = '0;
      end
      for (int k = NETWORK_PORTS - 1; k >= 0; k--) begin
         if (!post[k].word[0]) begin
            free_ok  = 1'b1;
            free_idx = PORT_IDX_BITS'(k);
         end
      end
   end

   // Injection queue: push the offered flit, inject the head into a free slot
   assign offer       = req_if.inject_word;
   assign push        = offer[0] && (qcount_ff < QCNT_BITS'(INJ_QUEUE_DEPTH));
   assign dropped     = offer[0] && !push;
   assign qcount_push = qcount_ff + QCNT_BITS'(push);
   assign pop         = (qcount_push != '0) && free_ok;
   assign head        = (qcount_ff == '0) ? offer : queue_ff[0];
   assign qcount_in   = qcount_push - QCNT_BITS'(pop);

   always_comb begin
      for (int i = 0; i < INJ_QUEUE_DEPTH - 1; i++) begin
         queue_shift[i] = queue_ff[i+1];
      end
      queue_shift[INJ_QUEUE_DEPTH-1] = queue_ff[INJ_QUEUE_DEPTH-1];
      for (int i = 0; i < INJ_QUEUE_DEPTH; i++) begin
         queue_in[i] = pop ? queue_shift[i] : queue_ff[i];
         if (push && pop && (QCNT_BITS'(i + 1) == qcount_ff)) queue_in[i] = offer;
         if (push && !pop && (QCNT_BITS'(i) == qcount_ff))    queue_in[i] = offer;
      end
   end

   always_comb begin
      for (int k = 0; k < NETWORK_PORTS; k++) begin
         stage_in[k] = post[k];
         if (pop && (free_idx == PORT_IDX_BITS'(k))) begin
            stage_in[k].word = head | FLIT_BITS'(1);
            stage_in[k].gold = (pkt_of(head) == golden_in);
         end
      end
   end

   // Configuration and router state
   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_length_ff <= EPOCH_LENGTH_RST;
         max_inject_ff   <= MAX_INJECT_RST;
         lfsr_seed_ff    <= LFSR_SEED_RST;
         lfsr_ff         <= LFSR_SEED_RST;
         golden_ff       <= GOLDEN_ID_RST;
         cycle_ff        <= '0;
         qcount_ff       <= '0;
         for (int k = 0; k < NETWORK_PORTS; k++) stage_ff[k] <= '0;
      end else begin
         if (accept) begin
            golden_ff <= golden_in;
            cycle_ff  <= cycle_in;
            qcount_ff <= qcount_in;
            for (int k = 0; k < NETWORK_PORTS; k++) stage_ff[k] <= stage_in[k];
         end
         // a seed write reloads the generator, else it follows the draws
         if (csr_write && (csr_idx == CSR_LFSR_SEED)) begin
            lfsr_ff <= (csr_pwdata[CFG_BITS-1:0] == '0) ?
                       cfg_type'(1) : csr_pwdata[CFG_BITS-1:0];
         end else if (accept) begin
            lfsr_ff <= lfsr_in;
         end
         if (csr_write) begin
            case (csr_idx)
               CSR_EPOCH_LENGTH: epoch_length_ff <= csr_pwdata[CFG_BITS-1:0];
               CSR_MAX_INJECT:   max_inject_ff   <= csr_pwdata[CFG_BITS-1:0];
               CSR_LFSR_SEED:    lfsr_seed_ff    <= csr_pwdata[CFG_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   // Queue storage, no reset: entries at or above the count are never read
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < INJ_QUEUE_DEPTH; i++) queue_ff[i] <= queue_in[i];
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int k = 0; k < NETWORK_PORTS; k++) link_out_ff[k] <= link_out[k];
         eject_ff   <= eject_word;
         defl_ff    <= defl_sum;
         stop_ff    <= (qcount_in != '0);
         dropped_ff <= dropped;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.north_flit     = link_out_ff[0];
   assign rsp_if.south_flit     = link_out_ff[1];
   assign rsp_if.east_flit      = link_out_ff[2];
   assign rsp_if.west_flit      = link_out_ff[3];
   assign rsp_if.eject_flit     = eject_ff;
   assign rsp_if.deflections    = defl_ff;
   assign rsp_if.inject_stop    = stop_ff;
   assign rsp_if.inject_dropped = dropped_ff;

endmodule

### rtl/drp_checker.sv
`timescale 1ns / 1ps
// Port-level checks for deflection_router_permuter_core, bound into the core module.
// Depends on drp_pkg and the drp_req_if / drp_rsp_if interfaces.
module drp_checker (
   input  logic       clock,
   input  logic       reset,
   drp_req_if.sink    req_if,
   drp_rsp_if.source  rsp_if
);
   import drp_pkg::*;

   // A free response register always takes a request
   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      (!rsp_if.valid || rsp_if.ready) |-> req_if.ready)
      else $error("request refused while response register is free");

   // Every accepted request shows a response on the next cycle
   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> rsp_if.valid)
      else $error("accepted request produced no response");

   // A stalled response is not lost
   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.ready) |=> rsp_if.valid)
      else $error("stalled response dropped");

   // Only local flits are ejected; no ejection reads as all zeros
   a_eject_local: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |->
         (rsp_if.eject_flit[0] && (rsp_if.eject_flit[3:1] == DIR_LOCAL)) ||
         (rsp_if.eject_flit == '0))
      else $error("malformed ejected flit");

   // At most one deflection per link
   a_defl_range: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.deflections <= DEFL_BITS'(NETWORK_PORTS)))
      else $error("deflection count out of range");

endmodule

bind deflection_router_permuter_core drp_checker u_drp_checker (
   .clock  (clock),
   .reset  (reset),
   .req_if (req_if),
   .rsp_if (rsp_if)
);

### sim/drp_route_check.sv
`timescale 1ns / 1ps
// Route checker for the deflection router permuter: predicts every response transaction
// from request and configuration channels, checks it. Depends on drp_pkg, drp_req_if.sv.
module drp_route_check
   import drp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   drp_req_if                       req,
   drp_rsp_if                       rsp,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   input  logic                     csr_pready,
   output int                       error_count,
   output int                       pending_count,
   output int                       checked_count
);

   localparam int INJ_DEPTH = 8;

   typedef struct packed {
      flit_type             north;
      flit_type             south;
      flit_type             east;
      flit_type             west;
      flit_type             eject;
      logic [DEFL_BITS-1:0] defl;
      logic                 stop;
      logic                 dropped;
   } router_out_type;

   // Predicted router state
   slot_type       held [NETWORK_PORTS];
   flit_type       inj_fifo [$];
   pkt_type        golden;
   logic [16:0]    phase;
   cfg_type        gen;
   cfg_type        epoch_len;
   cfg_type        max_inj;
   router_out_type expected_results [$];

   function automatic dir_type dir_bits(flit_type w);
      return w[DIR_LSB +: 3];
   endfunction

   function automatic fnum_type num_bits(flit_type w);
      return w[FNUM_LSB +: FLIT_NUM_BITS];
   endfunction

   // One tie-break bit; the generator moves only when a bit is drawn
   function automatic logic tie_bit();
      logic out, fb;
      out = gen[0];
      fb  = gen[0] ^ gen[2] ^ gen[3] ^ gen[5];
      gen = {fb, gen[CFG_BITS-1:1]};
      return out;
   endfunction

   // 1 when b wins over a
   function automatic logic choose_second(slot_type a, slot_type b);
      logic va, vb, ga, gb;
      va = a.word[0];
      vb = b.word[0];
      ga = va && a.gold;
      gb = vb && b.gold;
      if (ga && gb) return num_bits(b.word) < num_bits(a.word);
      if (ga) return 1'b0;
      if (gb) return 1'b1;
      if (!vb) return 1'b0;
      if (!va) return 1'b1;
      return tie_bit();
   endfunction

   function automatic logic wants_upper(flit_type w, logic second);
      dir_type d;
      d = dir_bits(w);
      if (!second) return (d == DIR_XP) || (d == DIR_XM);
      return (d == DIR_YM) || (d == DIR_XM);
   endfunction

   // 2x2 stage: 1 when the pair swaps
   function automatic logic crosses(slot_type a, slot_type b, logic second);
      logic w, p0, p1;
      if (!a.word[0] && !b.word[0]) return 1'b0;
      w  = choose_second(a, b);
      p0 = a.word[0] ? wants_upper(a.word, second) : 1'b0;
      p1 = b.word[0] ? wants_upper(b.word, second) : 1'b1;
      return (!w && p0) || (w && !p1);
   endfunction

   function automatic slot_type tag_gold(flit_type w);
      slot_type s;
      s.word = w;
      s.gold = (w[PKT_LSB +: PKT_ID_BITS] == golden);
      return s;
   endfunction

   // One router cycle: route held flits, advance epoch, register, eject, inject
   task automatic predict_cycle(input flit_type arrive [NETWORK_PORTS], input flit_type offer);
      slot_type       x1, x2, x3, x4;
      slot_type       sent [NETWORK_PORTS];
      flit_type       link [NETWORK_PORTS];
      router_out_type r;
      logic           sw, placed;
      logic [DEFL_BITS-1:0] defl;
      cfg_type        period;
      logic [NETWORK_PORTS-1:0] to_local;
      int             lo, hi, sel;

      sw = crosses(held[3], held[1], 1'b0);
      x1 = sw ? held[1] : held[3];
      x2 = sw ? held[3] : held[1];
      sw = crosses(held[2], held[0], 1'b0);
      x3 = sw ? held[0] : held[2];
      x4 = sw ? held[2] : held[0];
      sw = crosses(x1, x3, 1'b1);
      sent[0] = sw ? x3 : x1;
      sent[1] = sw ? x1 : x3;
      sw = crosses(x2, x4, 1'b1);
      sent[2] = sw ? x4 : x2;
      sent[3] = sw ? x2 : x4;
      defl = '0;
      for (int k = 0; k < NETWORK_PORTS; k++) begin
         link[k] = sent[k].word[0] ? sent[k].word : '0;
         if (sent[k].word[0] && dir_bits(sent[k].word) != WANT_DIR[k]) defl++;
      end

      // golden epoch; a zero length behaves as one
      period = (epoch_len == '0) ? cfg_type'(1) : epoch_len;
      if (phase >= {1'b0, period}) begin
         golden = (golden >= max_inj) ? pkt_type'(1) : golden + pkt_type'(1);
         phase  = 17'd1;
      end else begin
         phase = phase + 17'd1;
      end

      for (int k = 0; k < NETWORK_PORTS; k++)
         held[k] = arrive[k][0] ? tag_gold(arrive[k]) : '0;

      r = '0;
      r.north = link[0];
      r.south = link[1];
      r.east  = link[2];
      r.west  = link[3];
      r.defl  = defl;

      // ejection: pairwise winners, then the final pick
      for (int k = 0; k < NETWORK_PORTS; k++)
         to_local[k] = held[k].word[0] && dir_bits(held[k].word) == DIR_LOCAL;
      lo = -1;
      hi = -1;
      if (to_local[0] && to_local[1]) lo = choose_second(held[0], held[1]) ? 1 : 0;
      else if (to_local[0]) lo = 0;
      else if (to_local[1]) lo = 1;
      if (to_local[2] && to_local[3]) hi = choose_second(held[2], held[3]) ? 3 : 2;
      else if (to_local[2]) hi = 2;
      else if (to_local[3]) hi = 3;
      if (lo >= 0 && hi >= 0) sel = choose_second(held[lo], held[hi]) ? hi : lo;
      else sel = (lo >= 0) ? lo : hi;
      if (sel >= 0) begin
         r.eject   = held[sel].word;
         held[sel] = '0;
      end

      // injection queue, head goes to the lowest free slot
      if (offer[0]) begin
         if (inj_fifo.size() < INJ_DEPTH) inj_fifo.push_back(offer);
         else r.dropped = 1'b1;
      end
      placed = 1'b0;
      for (int k = 0; k < NETWORK_PORTS; k++) begin
         if (!placed && inj_fifo.size() != 0 && !held[k].word[0]) begin
            held[k] = tag_gold(inj_fifo[0] | flit_type'(1));
            void'(inj_fifo.pop_front());
            placed = 1'b1;
         end
      end
      r.stop = (inj_fifo.size() != 0);
      expected_results.push_back(r);
   endtask

   task automatic flag_error(string what);
      $display("%0t ns route_check: %s", $time, what);
      error_count++;
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         flag_error($sformatf("response %0d field %s: got %h, expected %h",
                              checked_count, name, got, want));
   endtask

   // Watch all channels at the rising edge
   always @(posedge clock) begin : watch
      flit_type       arrivals [NETWORK_PORTS];
      router_out_type seen, want;
      cfg_type        value;

      if (reset) begin
         foreach (held[k]) held[k] = '0;
         inj_fifo.delete();
         expected_results.delete();
         golden        = GOLDEN_ID_RST;
         phase         = '0;
         gen           = LFSR_SEED_RST;
         epoch_len     = EPOCH_LENGTH_RST;
         max_inj       = MAX_INJECT_RST;
         error_count   = 0;
         checked_count = 0;
      end else begin
         // register write
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            value = csr_pwdata[CFG_BITS-1:0];
            case (csr_idx_type'(csr_paddr >> 2))
               CSR_EPOCH_LENGTH: epoch_len = value;
               CSR_MAX_INJECT:   max_inj = value;
               CSR_LFSR_SEED:    gen = (value == '0) ? cfg_type'(1) : value;
               default: ;
            endcase
         end
         // request transaction
         if (req.valid && req.ready) begin
            arrivals[0] = req.in_slot_1;
            arrivals[1] = req.in_slot_2;
            arrivals[2] = req.in_slot_3;
            arrivals[3] = req.in_slot_4;
            predict_cycle(arrivals, req.inject_word);
         end
         // response transaction
         if (rsp.valid && rsp.ready) begin
            if (expected_results.size() == 0) begin
               flag_error("response with nothing expected");
            end else begin
               want = expected_results.pop_front();
               seen = '{rsp.north_flit, rsp.south_flit, rsp.east_flit, rsp.west_flit,
                        rsp.eject_flit, rsp.deflections, rsp.inject_stop, rsp.inject_dropped};
               check_field("north_flit", 32'(seen.north), 32'(want.north));
               check_field("south_flit", 32'(seen.south), 32'(want.south));
               check_field("east_flit", 32'(seen.east), 32'(want.east));
               check_field("west_flit", 32'(seen.west), 32'(want.west));
               check_field("eject_flit", 32'(seen.eject), 32'(want.eject));
               check_field("deflections", 32'(seen.defl), 32'(want.defl));
               check_field("inject_stop", 32'(seen.stop), 32'(want.stop));
               check_field("inject_dropped", 32'(seen.dropped), 32'(want.dropped));
               checked_count++;
            end
         end
      end
      pending_count <= expected_results.size();
   end

endmodule

### sim/tb_deflection_router_permuter_core.sv
`timescale 1ns / 1ps
// Top of the deflection router permuter testbench: clock, reset, stimulus, verdict.
// Depends on drp_pkg, drp_req_if.sv, the core and sim/drp_route_check.sv.
module tb_deflection_router_permuter_core;
   import drp_pkg::*;

   localparam int HALF_PERIOD = 4;
   localparam int BLOCK_ITEMS = 330;

   logic                     clock;
   logic                     reset;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   int error_count, pending_count, checked_count;
   int send_idle_pct, recv_idle_pct;
   int items_sent, directed_items;

   drp_req_if req_bus ();
   drp_rsp_if rsp_bus ();

   deflection_router_permuter_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   drp_route_check route_check (
      .clock         (clock),
      .reset         (reset),
      .req           (req_bus),
      .rsp           (rsp_bus),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_pready    (csr_pready),
      .error_count   (error_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Receiver stalls at random
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   function automatic flit_type make_flit(logic v, dir_type d, fnum_type n, pkt_type p);
      return {p, n, d, v};
   endfunction

   // Mostly small packet ids so golden matches are frequent; some raw noise words
   function automatic flit_type rand_flit(int valid_pct);
      logic     v;
      dir_type  d;
      fnum_type n;
      pkt_type  p;
      if ($urandom_range(0, 99) < 8) return flit_type'($urandom);
      v = ($urandom_range(0, 99) < valid_pct);
      d = ($urandom_range(0, 9) == 0) ? dir_type'($urandom_range(5, 7))
                                      : dir_type'($urandom_range(0, 4));
      n = $urandom_range(0, 1) ? fnum_type'($urandom_range(0, 3)) : fnum_type'($urandom);
      p = ($urandom_range(0, 3) != 0) ? pkt_type'($urandom_range(0, 6)) : pkt_type'($urandom);
      return make_flit(v, d, n, p);
   endfunction

   // Offer one router cycle; entered and left just after a falling edge
   task automatic send_step(input flit_type f1, f2, f3, f4, fi);
      logic took;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.in_slot_1   <= f1;
      req_bus.in_slot_2   <= f2;
      req_bus.in_slot_3   <= f3;
      req_bus.in_slot_4   <= f4;
      req_bus.inject_word <= fi;
      do begin
         @(posedge clock);
         took = req_bus.ready;
         @(negedge clock);
      end while (!took);
      items_sent++;
   endtask

   // Hold off the sender until every response has come back
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(csr_idx_type idx, cfg_type value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {16'($urandom), value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Idle rates change at a rising edge so the receiver never races the update
   task automatic set_idle(int send_pct, int recv_pct);
      @(posedge clock);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      @(negedge clock);
   endtask

   initial begin
      cfg_type ep, mx, sd;
      int      slot_pct, inject_pct;

      clock               = 1'b0;
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.in_slot_1   = '0;
      req_bus.in_slot_2   = '0;
      req_bus.in_slot_3   = '0;
      req_bus.in_slot_4   = '0;
      req_bus.inject_word = '0;
      rsp_bus.ready       = 1'b0;
      csr_psel            = 1'b0;
      csr_penable         = 1'b0;
      csr_pwrite          = 1'b0;
      csr_paddr           = '0;
      csr_pwdata          = '0;
      send_idle_pct       = 22;
      recv_idle_pct       = 53;
      items_sent          = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty cycle, all-ones words
      send_step('0, '0, '0, '0, '0);
      send_step('1, '1, '1, '1, '1);
      // every direction code; two golden slots tie on flit number, two plain slots
      // at the packet id extremes draw random bits; offered word invalid but nonzero
      for (int d = 0; d < 8; d++)
         send_step(make_flit(1'b1, dir_type'(d), 8'h00, GOLDEN_ID_RST),
                   make_flit(1'b1, dir_type'(d), 8'h00, GOLDEN_ID_RST),
                   make_flit(1'b1, dir_type'(d), 8'hFF, 16'hFFFF),
                   make_flit(1'b1, dir_type'(d), 8'hFF, 16'h0000),
                   make_flit(1'b0, dir_type'(d), 8'h01, 16'h0001));
      // links full so the queue fills and then drops
      for (int k = 0; k < 10; k++)
         send_step(make_flit(1'b1, DIR_XP, fnum_type'(k), 16'h0002),
                   make_flit(1'b1, DIR_XM, fnum_type'(k + 1), 16'h0002),
                   make_flit(1'b1, DIR_YP, 8'h00, 16'h0002),
                   make_flit(1'b1, DIR_YM, 8'hFF, 16'h0002),
                   make_flit(1'b1, DIR_LOCAL, fnum_type'(k), 16'h0003));
      // free slots let queued flits inject
      send_step('0, '0, '0, '0, '0);
      send_step('0, '0, '0, '0, '0);
      directed_items = items_sent;

      // Random blocks, one register setting each
      for (int blk = 0; blk < 6; blk++) begin
         wait_drained();
         if (blk == 2) set_idle(53, 22);
         if (blk == 4) set_idle(0, 0);
         case (blk)
            0: begin ep = 16'd1;     mx = 16'd4;     sd = 16'hACE1; end
            1: begin ep = 16'd0;     mx = 16'd1;     sd = 16'd0;    end
            2: begin ep = 16'hFFFF;  mx = 16'hFFFF;  sd = 16'hFFFF; end
            3: begin
               ep = cfg_type'($urandom_range(1, 16));
               mx = cfg_type'($urandom_range(2, 8));
               sd = cfg_type'($urandom_range(1, 65535));
            end
            4: begin ep = 16'd2;     mx = 16'd3;     sd = 16'd1;    end
            default: begin
               ep = cfg_type'($urandom_range(1, 65535));
               mx = cfg_type'($urandom_range(1, 65535));
               sd = cfg_type'($urandom_range(1, 65535));
            end
         endcase
         write_reg(CSR_EPOCH_LENGTH, ep);
         write_reg(CSR_MAX_INJECT, mx);
         write_reg(CSR_LFSR_SEED, sd);
         slot_pct   = (blk == 4) ? 95 : $urandom_range(30, 95);
         inject_pct = (blk == 4) ? 95 : $urandom_range(20, 95);
         for (int n = 0; n < BLOCK_ITEMS; n++) begin
            if (blk == 1 && n == BLOCK_ITEMS / 2) wait_drained();
            send_step(rand_flit(slot_pct), rand_flit(slot_pct), rand_flit(slot_pct),
                      rand_flit(slot_pct), rand_flit(inject_pct));
         end
      end

      wait_drained();
      $display("Covered %0d router cycles (%0d directed) and %0d checked responses,",
               items_sent, directed_items, checked_count);
      $display("six register settings, three idle profiles, one mid-run drain.");
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("Timeout with %0d responses outstanding", pending_count);
      $display("*** FAILED ***");
      $finish;
   end

endmodule

### sim.f
rtl/drp_pkg.sv
rtl/drp_req_if.sv
rtl/deflection_router_permuter_core.sv
rtl/drp_checker.sv
sim/drp_route_check.sv
sim/tb_deflection_router_permuter_core.sv
